>>> design/ycbcr_to_rgb_pixel_packer_defines.svh
// ----------------------------------------------------------------------------
// YCbCr to RGB pixel packer: assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef YCBCR_TO_RGB_PIXEL_PACKER_DEFINES_SVH
`define YCBCR_TO_RGB_PIXEL_PACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define Y2RGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define Y2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define Y2RGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define Y2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/y2rgb_pkg.sv
// ----------------------------------------------------------------------------
// YCbCr to RGB pixel packer package
// Widths, codes, stage types, luma expansion ROM and clipping functions.
// ----------------------------------------------------------------------------
package y2rgb_pkg;

  localparam int PIX_W     = 8;
  localparam int GAIN_W    = 18;
  localparam int FMT_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PACK_W    = 64;
  localparam int BYTES_W   = 4;
  localparam int PROD_W    = 28;
  localparam int SUM_W     = 29;

  typedef enum logic [FMT_W-1:0] {
    FMT_BGR888   = 3'd0,
    FMT_BGRA8888 = 3'd1,
    FMT_RGB565   = 3'd2,
    FMT_RGB888   = 3'd3,
    FMT_RGBA8888 = 3'd4,
    FMT_RGBA16   = 3'd5
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_FORMAT    = 3'd0,
    REG_LUMA_EXPAND   = 3'd1,
    REG_GAIN_CR_RED   = 3'd2,
    REG_GAIN_CR_GREEN = 3'd3,
    REG_GAIN_CB_GREEN = 3'd4,
    REG_GAIN_CB_BLUE  = 3'd5
  } cfg_idx_t;

  localparam logic [FMT_W-1:0]  RST_OUT_FORMAT    = FMT_RGB888;
  localparam logic              RST_LUMA_EXPAND   = 1'b0;
  localparam logic [GAIN_W-1:0] RST_GAIN_CR_RED   = 18'd89849;
  localparam logic [GAIN_W-1:0] RST_GAIN_CR_GREEN = 18'd45744;
  localparam logic [GAIN_W-1:0] RST_GAIN_CB_GREEN = 18'd22020;
  localparam logic [GAIN_W-1:0] RST_GAIN_CB_BLUE  = 18'd113508;

  localparam logic [7:0]         ALPHA8      = 8'hFF;
  localparam logic [15:0]        ALPHA16     = 16'h7FFF;
  localparam logic [BYTES_W-1:0] BYTES_565   = 4'd2;
  localparam logic [BYTES_W-1:0] BYTES_888   = 4'd3;
  localparam logic [BYTES_W-1:0] BYTES_8888  = 4'd4;
  localparam logic [BYTES_W-1:0] BYTES_WIDE  = 4'd8;

  typedef struct packed {
    logic [FMT_W-1:0]  out_format;
    logic              luma_expand;
    logic [GAIN_W-1:0] gain_cr_red;
    logic [GAIN_W-1:0] gain_cr_green;
    logic [GAIN_W-1:0] gain_cb_green;
    logic [GAIN_W-1:0] gain_cb_blue;
  } cfg_t;

  // first stage: luma after expansion and the four chroma products
  typedef struct packed {
    logic [PIX_W-1:0]         y;
    logic signed [PROD_W-1:0] p_cr_red;
    logic signed [PROD_W-1:0] p_cr_green;
    logic signed [PROD_W-1:0] p_cb_green;
    logic signed [PROD_W-1:0] p_cb_blue;
  } s1_t;

  typedef logic [PIX_W-1:0] luma_rom_t [256];

  // rom[i] = floor(1.1644*i - 255*0.0627 + 0.5), clipped to 0..255
  function automatic luma_rom_t build_luma_rom();
    luma_rom_t rom;
    int        t;
    int        v;
    for (int i = 0; i < 256; i++) begin
      t = 11644 * i - 154885;
      if (t < 0) begin
        v = 0;
      end else begin
        v = t / 10000;
      end
      if (v > 255) begin
        v = 255;
      end
      rom[i] = v[PIX_W-1:0];
    end
    return rom;
  endfunction

  localparam luma_rom_t LUMA_ROM = build_luma_rom();

  // floor shift by 16, clip to 0..255
  function automatic logic [7:0] clip_u8(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-17:0] q;
    q = $signed(s[SUM_W-1:16]);
    if (q < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

  // floor shift by 8, clip to signed 16 bits
  function automatic logic [15:0] clip_s16(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-9:0] q;
    q = $signed(s[SUM_W-1:8]);
    if (q < -32768) begin
      return 16'h8000;
    end else if (q > 32767) begin
      return 16'h7FFF;
    end else begin
      return q[15:0];
    end
  endfunction

endpackage

>>> design/y2rgb_if.sv
// ----------------------------------------------------------------------------
// YCbCr to RGB pixel packer channels
// Valid/ready interfaces for pixel input, packed output and register writes.
// ----------------------------------------------------------------------------
interface y2rgb_in_if;
  logic                         valid;
  logic                         ready;
  logic [y2rgb_pkg::PIX_W-1:0]  luma;
  logic [y2rgb_pkg::PIX_W-1:0]  chroma_blue;
  logic [y2rgb_pkg::PIX_W-1:0]  chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

interface y2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [y2rgb_pkg::PACK_W-1:0]   packed_pixel;
  logic [y2rgb_pkg::BYTES_W-1:0]  pixel_bytes;

  modport source (output valid, output packed_pixel, output pixel_bytes, input ready);
  modport sink   (input valid, input packed_pixel, input pixel_bytes, output ready);
endinterface

interface y2rgb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [y2rgb_pkg::CFG_IDX_W-1:0]  index;
  logic [y2rgb_pkg::GAIN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/y2rgb_cfg.sv
// ----------------------------------------------------------------------------
// YCbCr to RGB pixel packer register file
// Holds output format, luma expansion enable and the four chroma gains.
// ----------------------------------------------------------------------------
module y2rgb_cfg (
  input  logic              clk,
  input  logic              rst_n,
  y2rgb_cfg_if.sink         cfg_wr,
  output y2rgb_pkg::cfg_t   cfg_q
);
  import y2rgb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg_q        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        REG_OUT_FORMAT:    cfg_nxt.out_format    = cfg_wr.data[FMT_W-1:0];
        REG_LUMA_EXPAND:   cfg_nxt.luma_expand   = cfg_wr.data[0];
        REG_GAIN_CR_RED:   cfg_nxt.gain_cr_red   = cfg_wr.data;
        REG_GAIN_CR_GREEN: cfg_nxt.gain_cr_green = cfg_wr.data;
        REG_GAIN_CB_GREEN: cfg_nxt.gain_cb_green = cfg_wr.data;
        REG_GAIN_CB_BLUE:  cfg_nxt.gain_cb_blue  = cfg_wr.data;
        // drop writes to unmapped indexes
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_format    <= RST_OUT_FORMAT;
      cfg_r.luma_expand   <= RST_LUMA_EXPAND;
      cfg_r.gain_cr_red   <= RST_GAIN_CR_RED;
      cfg_r.gain_cr_green <= RST_GAIN_CR_GREEN;
      cfg_r.gain_cb_green <= RST_GAIN_CB_GREEN;
      cfg_r.gain_cb_blue  <= RST_GAIN_CB_BLUE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/y2rgb_pack.sv
// ----------------------------------------------------------------------------
// YCbCr to RGB pixel packer output stage logic
// Sums luma and chroma products, clips each channel and packs the pixel.
// ----------------------------------------------------------------------------
module y2rgb_pack (
  input  y2rgb_pkg::s1_t                   s1,
  input  y2rgb_pkg::cfg_t                  cfg,
  output logic [y2rgb_pkg::PACK_W-1:0]     packed_pixel,
  output logic [y2rgb_pkg::BYTES_W-1:0]    pixel_bytes
);
  import y2rgb_pkg::*;

  logic signed [SUM_W-1:0] y_s;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;
  logic [7:0]              r8;
  logic [7:0]              g8;
  logic [7:0]              b8;
  logic [15:0]             r16;
  logic [15:0]             g16;
  logic [15:0]             b16;
  logic [15:0]             w565;

  assign y_s   = $signed({{(SUM_W-PIX_W-16){1'b0}}, s1.y, 16'd0});
  assign sum_r = y_s + SUM_W'(s1.p_cr_red);
  assign sum_g = y_s - SUM_W'(s1.p_cr_green) - SUM_W'(s1.p_cb_green);
  assign sum_b = y_s + SUM_W'(s1.p_cb_blue);

  assign r8  = clip_u8(sum_r);
  assign g8  = clip_u8(sum_g);
  assign b8  = clip_u8(sum_b);
  assign r16 = clip_s16(sum_r);
  assign g16 = clip_s16(sum_g);
  assign b16 = clip_s16(sum_b);

  assign w565 = {r8[7:3], g8[7:2], b8[7:3]};

  always_comb begin
    unique case (fmt_t'(cfg.out_format))
      FMT_BGR888: begin
        packed_pixel = {40'd0, r8, g8, b8};
        pixel_bytes  = BYTES_888;
      end
      FMT_BGRA8888: begin
        packed_pixel = {32'd0, ALPHA8, r8, g8, b8};
        pixel_bytes  = BYTES_8888;
      end
      FMT_RGB565: begin
        packed_pixel = {48'd0, w565};
        pixel_bytes  = BYTES_565;
      end
      FMT_RGBA8888: begin
        packed_pixel = {32'd0, ALPHA8, b8, g8, r8};
        pixel_bytes  = BYTES_8888;
      end
      FMT_RGBA16: begin
        packed_pixel = {ALPHA16, b16, g16, r16};
        pixel_bytes  = BYTES_WIDE;
      end
      // RGB888 and the unused codes
      default: begin
        packed_pixel = {40'd0, b8, g8, r8};
        pixel_bytes  = BYTES_888;
      end
    endcase
  end

endmodule

>>> design/ycbcr_to_rgb_pixel_packer.sv
// An accepted request is registered in stage 1, then in the stage 2 register that drives out_px.
// Throughput: one pixel per cycle; a stage advances when the one after it is empty or being taken.
// Stage 1 registers luma (via the expansion ROM when enabled, except for RGBA16) and four 18x9 chroma products;
// stage 2 forms the sums and clipped channels and registers the packed word and byte count.
// Reset (rst_n low, synchronous): pipeline emptied, registers back to RGB888,
// no expansion and the BT.601 default gains.
// ----------------------------------------------------------------------------
// YCbCr to RGB pixel packer
// Converts one YCbCr pixel per cycle, when the output is not stalled, to a packed BGR/RGB/RGBA output pixel.
// ----------------------------------------------------------------------------
`include "ycbcr_to_rgb_pixel_packer_defines.svh"

module ycbcr_to_rgb_pixel_packer (
  input  logic          clk,
  input  logic          rst_n,
  y2rgb_in_if.sink      in_px,
  y2rgb_out_if.source   out_px,
  y2rgb_cfg_if.sink     cfg_wr
);
  import y2rgb_pkg::*;

  cfg_t                    cfg_q;
  s1_t                     s1_r;
  s1_t                     s1_nxt;
  logic                    s1_v_r;
  logic                    s1_v_nxt;
  logic                    out_v_r;
  logic                    out_v_nxt;
  logic [PACK_W-1:0]       packed_r;
  logic [PACK_W-1:0]       packed_nxt;
  logic [BYTES_W-1:0]      bytes_r;
  logic [BYTES_W-1:0]      bytes_nxt;
  logic                    out_free;
  logic                    in_acc;
  logic                    wide;
  logic signed [PIX_W:0]   dcb;
  logic signed [PIX_W:0]   dcr;

  y2rgb_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg_q  (cfg_q)
  );

  // handshake: stage 2 frees when empty or taken, stage 1 when it can move on
  assign out_free     = !out_v_r || out_px.ready;
  assign in_px.ready  = !s1_v_r || out_free;
  assign in_acc       = in_px.valid && in_px.ready;

  assign s1_v_nxt  = in_px.ready ? in_px.valid : s1_v_r;
  assign out_v_nxt = out_free ? s1_v_r : out_v_r;

  // stage 1: luma expansion and chroma products
  assign wide = (fmt_t'(cfg_q.out_format) == FMT_RGBA16);
  assign dcb  = $signed({1'b0, in_px.chroma_blue}) - $signed(9'd128);
  assign dcr  = $signed({1'b0, in_px.chroma_red}) - $signed(9'd128);

  always_comb begin
    s1_nxt.y          = (cfg_q.luma_expand && !wide) ? LUMA_ROM[in_px.luma] : in_px.luma;
    s1_nxt.p_cr_red   = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg_q.gain_cr_red}) * PROD_W'(dcr);
    s1_nxt.p_cr_green = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg_q.gain_cr_green}) * PROD_W'(dcr);
    s1_nxt.p_cb_green = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg_q.gain_cb_green}) * PROD_W'(dcb);
    s1_nxt.p_cb_blue  = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg_q.gain_cb_blue}) * PROD_W'(dcb);
  end

  // stage 2: sum, clip, pack
  y2rgb_pack u_pack (
    .s1           (s1_r),
    .cfg          (cfg_q),
    .packed_pixel (packed_nxt),
    .pixel_bytes  (bytes_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (out_free && s1_v_r) begin
      packed_r <= packed_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

  assign out_px.valid        = out_v_r;
  assign out_px.packed_pixel = packed_r;
  assign out_px.pixel_bytes  = bytes_r;

  `Y2RGB_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_acc, s1_v_r)
  `Y2RGB_ASSERT_NEXT(a_s1_holds_on_stall, clk, rst_n, s1_v_r && !out_free,
    s1_v_r && $stable(s1_r))
  `Y2RGB_ASSERT_IMP(a_bytes_legal, clk, rst_n, out_v_r,
    (bytes_r == BYTES_565) || (bytes_r == BYTES_888) ||
    (bytes_r == BYTES_8888) || (bytes_r == BYTES_WIDE))
  `Y2RGB_ASSERT_IMP(a_wide_alpha, clk, rst_n, out_v_r && (bytes_r == BYTES_WIDE),
    packed_r[PACK_W-1:PACK_W-16] == ALPHA16)

endmodule
